### rtl/velocity_command_governor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the velocity command governor
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_COMMAND_GOVERNOR_MACROS_SVH
`define VELOCITY_COMMAND_GOVERNOR_MACROS_SVH

// Same-cycle implication.
`define VCG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VCG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vcg_pkg.sv
// ----------------------------------------------------------------------------
// vcg_pkg
// Shared types and constants of the velocity command governor.
// ----------------------------------------------------------------------------
package vcg_pkg;

  localparam int VEL_W      = 16;
  localparam int LIM_W      = 15;
  localparam int TMO_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int VAL_W      = 8;
  localparam int WALK_W     = 3;
  localparam int SQ_W       = 2 * VEL_W;
  localparam int PROD_W     = VEL_W + LIM_W;
  localparam int ITER_N     = VEL_W;
  localparam int CNT_W      = $clog2(ITER_N);

  localparam logic [LIM_W-1:0] SPORT_RST   = LIM_W'(12288);
  localparam logic [LIM_W-1:0] AI_HIGH_RST = LIM_W'(8192);
  localparam logic [LIM_W-1:0] AI_LOW_RST  = LIM_W'(4096);
  localparam logic [TMO_W-1:0] TMO_RST     = TMO_W'(500);

  localparam logic [VAL_W-1:0] VAL_ZERO = VAL_W'(0);
  localparam logic [VAL_W-1:0] VAL_ONE  = VAL_W'(1);
  localparam logic [VAL_W-1:0] VAL_FOUR = VAL_W'(4);

  typedef enum logic [3:0] {
    ACT_MOVE       = 4'd0,
    ACT_STOP       = 4'd1,
    ACT_GAIT       = 4'd2,
    ACT_WALK_MODE  = 4'd3,
    ACT_PROFILE    = 4'd4,
    ACT_SPEED      = 4'd5,
    ACT_CONTINUOUS = 4'd6,
    ACT_RESET      = 4'd7,
    ACT_TICK       = 4'd8
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPORT   = 2'd0,
    CFG_AI_HIGH = 2'd1,
    CFG_AI_LOW  = 2'd2,
    CFG_TIMEOUT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    LIM_SPORT,
    LIM_AI_HIGH,
    LIM_AI_LOW
  } lim_sel_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_START,
    DP_SQUARE,
    DP_COMPARE,
    DP_SQRT,
    DP_MUL,
    DP_DIV,
    DP_COMMIT,
    DP_ZERO,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    logic     src_in;
    lim_sel_t lim_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic over;
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_COMPARE,
    S_TEST,
    S_SQRT,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

endpackage

### rtl/velocity_command_governor.sv
// ----------------------------------------------------------------------------
// velocity_command_governor
// Gates, clamps and publishes planar velocity commands with a tick watchdog.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in       | in_valid / in_ready  | in_action, in_vel_x/y/yaw, in_value, in_enable
//  out      | out_valid / out_ready| out_vx, out_vy, out_yaw, out_is_stop
//  cfg      | cfg_we               | cfg_index, cfg_wdata
//
// A non-clamping command completes in the IDLE state. A move or re-limit
// steps through SQUARE, COMPARE, TEST and COMMIT when within the limit and
// adds SQRT, MUL and DIV when clamped: the shared isqrt unit and the pair
// of restoring dividers each retire one step per cycle. One command is in
// flight at a time; a new one enters only while the output register is empty or being taken. Synchronous reset.
// ----------------------------------------------------------------------------
`include "velocity_command_governor_macros.svh"

module velocity_command_governor
  import vcg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3:0]              in_action,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic signed [VEL_W-1:0] in_vel_yaw,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_enable,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VEL_W-1:0] out_vx,
  output logic signed [VEL_W-1:0] out_vy,
  output logic signed [VEL_W-1:0] out_yaw,
  output logic                    out_is_stop,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    busy;

  vcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .in_value  (in_value),
    .in_enable (in_enable),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts),
    .busy      (busy)
  );

  vcg_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_vel_x    (in_vel_x),
    .in_vel_y    (in_vel_y),
    .in_vel_yaw  (in_vel_yaw),
    .out_vx      (out_vx),
    .out_vy      (out_vy),
    .out_yaw     (out_yaw),
    .out_is_stop (out_is_stop)
  );

  `VCG_ASSERT_IMP(a_busy_blocks_in, busy, !in_ready, "input taken while clamp in progress")
  `VCG_ASSERT_IMP(a_full_out_blocks_in, out_valid && !out_ready, !in_ready, "input taken with output held")
  `VCG_ASSERT_IMP(a_stop_flag, out_valid, out_is_stop == ((out_vx == '0) && (out_vy == '0) && (out_yaw == '0)), "stop flag mismatch")

endmodule

### rtl/vcg_dp.sv
// ----------------------------------------------------------------------------
// vcg_dp
// Datapath: limit registers, planar clamp (square, isqrt, scale, divide),
// last velocity and the published twist.
// ----------------------------------------------------------------------------
module vcg_dp
  import vcg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_sts_t                sts,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic signed [VEL_W-1:0] in_vel_x,
  input  logic signed [VEL_W-1:0] in_vel_y,
  input  logic signed [VEL_W-1:0] in_vel_yaw,
  output logic signed [VEL_W-1:0] out_vx,
  output logic signed [VEL_W-1:0] out_vy,
  output logic signed [VEL_W-1:0] out_yaw,
  output logic                   out_is_stop
);

  logic [LIM_W-1:0] sport_r, ai_high_r, ai_low_r;

  logic signed [VEL_W-1:0] last_vx_r, last_vy_r, last_yaw_r;
  logic signed [VEL_W-1:0] vx_r, vy_r, yaw_r;
  logic [VEL_W-1:0]        ax_r, ay_r;
  logic [LIM_W-1:0]        lim_r;
  logic [SQ_W-1:0]         sqx_r, sqy_r, lsq_r;
  logic                    over_r;
  logic [SQ_W-1:0]         s_r, res_r, bit_r;
  logic [VEL_W-1:0]        remx_r, remy_r, qx_r, qy_r;
  logic signed [VEL_W-1:0] ovx_r, ovy_r, oyaw_r;
  logic                    ostop_r;

  logic signed [VEL_W-1:0] src_x, src_y, src_yaw;
  logic [LIM_W-1:0]        lim_sel_val;
  logic [SQ_W:0]           sum, trial;
  logic [PROD_W-1:0]       prod_x, prod_y;
  logic [VEL_W-1:0]        m;
  logic [VEL_W:0]          tx, ty;
  logic signed [VEL_W-1:0] rx, ry;

  always_comb begin
    src_x   = cmd.src_in ? in_vel_x   : last_vx_r;
    src_y   = cmd.src_in ? in_vel_y   : last_vy_r;
    src_yaw = cmd.src_in ? in_vel_yaw : last_yaw_r;
    unique case (cmd.lim_sel)
      LIM_SPORT:   lim_sel_val = sport_r;
      LIM_AI_HIGH: lim_sel_val = ai_high_r;
      default:     lim_sel_val = ai_low_r;
    endcase
    sum    = {1'b0, sqx_r} + {1'b0, sqy_r};
    trial  = {1'b0, res_r} + {1'b0, bit_r};
    prod_x = PROD_W'(ax_r) * PROD_W'(lim_r);
    prod_y = PROD_W'(ay_r) * PROD_W'(lim_r);
    m      = res_r[VEL_W-1:0];
    tx     = {remx_r, qx_r[VEL_W-1]};
    ty     = {remy_r, qy_r[VEL_W-1]};
    rx     = over_r ? (vx_r[VEL_W-1] ? -$signed(qx_r) : $signed(qx_r)) : vx_r;
    ry     = over_r ? (vy_r[VEL_W-1] ? -$signed(qy_r) : $signed(qy_r)) : vy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sport_r   <= SPORT_RST;
      ai_high_r <= AI_HIGH_RST;
      ai_low_r  <= AI_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPORT:   sport_r   <= cfg_wdata[LIM_W-1:0];
        CFG_AI_HIGH: ai_high_r <= cfg_wdata[LIM_W-1:0];
        CFG_AI_LOW:  ai_low_r  <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vx_r  <= '0;
      last_vy_r  <= '0;
      last_yaw_r <= '0;
    end else if (cmd.op == DP_CLEAR) begin
      last_vx_r  <= '0;
      last_vy_r  <= '0;
      last_yaw_r <= '0;
    end else if (cmd.op == DP_COMMIT) begin
      last_vx_r  <= rx;
      last_vy_r  <= ry;
      last_yaw_r <= yaw_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_START: begin
        vx_r  <= src_x;
        vy_r  <= src_y;
        yaw_r <= src_yaw;
        ax_r  <= src_x[VEL_W-1] ? VEL_W'(-src_x) : src_x;
        ay_r  <= src_y[VEL_W-1] ? VEL_W'(-src_y) : src_y;
        lim_r <= lim_sel_val;
      end
      DP_SQUARE: begin
        sqx_r <= SQ_W'(ax_r) * SQ_W'(ax_r);
        sqy_r <= SQ_W'(ay_r) * SQ_W'(ay_r);
        lsq_r <= SQ_W'(lim_r) * SQ_W'(lim_r);
      end
      DP_COMPARE: begin
        over_r <= sum > {1'b0, lsq_r};
        s_r    <= sum[SQ_W-1:0];
        res_r  <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end
      DP_SQRT: begin
        if ({1'b0, s_r} >= trial) begin
          s_r   <= s_r - trial[SQ_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      DP_MUL: begin
        // quotient never exceeds the magnitude, so the high part is below m
        remx_r <= VEL_W'(prod_x >> VEL_W);
        remy_r <= VEL_W'(prod_y >> VEL_W);
        qx_r   <= prod_x[VEL_W-1:0];
        qy_r   <= prod_y[VEL_W-1:0];
      end
      DP_DIV: begin
        if (tx >= {1'b0, m}) begin
          remx_r <= VEL_W'(tx - {1'b0, m});
          qx_r   <= {qx_r[VEL_W-2:0], 1'b1};
        end else begin
          remx_r <= tx[VEL_W-1:0];
          qx_r   <= {qx_r[VEL_W-2:0], 1'b0};
        end
        if (ty >= {1'b0, m}) begin
          remy_r <= VEL_W'(ty - {1'b0, m});
          qy_r   <= {qy_r[VEL_W-2:0], 1'b1};
        end else begin
          remy_r <= ty[VEL_W-1:0];
          qy_r   <= {qy_r[VEL_W-2:0], 1'b0};
        end
      end
      DP_COMMIT: begin
        ovx_r   <= rx;
        ovy_r   <= ry;
        oyaw_r  <= yaw_r;
        ostop_r <= (rx == '0) && (ry == '0) && (yaw_r == '0);
      end
      DP_ZERO, DP_CLEAR: begin
        ovx_r   <= '0;
        ovy_r   <= '0;
        oyaw_r  <= '0;
        ostop_r <= 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.over    = over_r;
  assign out_vx      = ovx_r;
  assign out_vy      = ovy_r;
  assign out_yaw     = oyaw_r;
  assign out_is_stop = ostop_r;

endmodule

### rtl/vcg_ctrl.sv
// ----------------------------------------------------------------------------
// vcg_ctrl
// Controller: command decode, governor flags, tick watchdog and the
// sequencer that steps the datapath through a planar clamp.
// ----------------------------------------------------------------------------
module vcg_ctrl
  import vcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            in_action,
  input  logic [VAL_W-1:0]      in_value,
  input  logic                  in_enable,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dp_cmd_t               dp_cmd,
  input  dp_sts_t               dp_sts,
  output logic                  busy
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              locked_r, locked_nxt;
  logic              active_r, active_nxt;
  logic              cont_r, cont_nxt;
  logic              sport_r, sport_nxt;
  logic              high_r, high_nxt;
  logic [WALK_W-1:0] walk_r, walk_nxt;
  logic [TMO_W-1:0]  ticks_r, ticks_nxt;
  logic [TMO_W-1:0]  timeout_r;
  logic              ovalid_r, ovalid_nxt;

  logic              out_free, accept, val_ok, last_iter;
  logic [TMO_W-1:0]  ticks_inc;

  assign out_free  = !ovalid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign val_ok    = (in_value >= VAL_ONE) && (in_value <= VAL_FOUR);
  assign last_iter = (cnt_r == CNT_W'(ITER_N - 1));
  assign ticks_inc = (ticks_r == '1) ? ticks_r : ticks_r + TMO_W'(1);
  assign out_valid = ovalid_r;
  assign busy      = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    locked_nxt = locked_r;
    active_nxt = active_r;
    cont_nxt   = cont_r;
    sport_nxt  = sport_r;
    high_nxt   = high_r;
    walk_nxt   = walk_r;
    ticks_nxt  = ticks_r;
    ovalid_nxt = ovalid_r && !out_ready;
    dp_cmd.op      = DP_NOP;
    dp_cmd.src_in  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_MOVE: begin
              if (!locked_r) begin
                dp_cmd.op     = DP_START;
                dp_cmd.src_in = 1'b1;
                ticks_nxt     = '0;
                active_nxt    = 1'b1;
                state_nxt     = S_SQUARE;
              end
            end
            ACT_STOP: begin
              active_nxt = 1'b0;
              dp_cmd.op  = DP_ZERO;
              ovalid_nxt = 1'b1;
            end
            ACT_GAIT: begin
              if (in_value == VAL_ZERO) begin
                locked_nxt = 1'b1;
                active_nxt = 1'b0;
                dp_cmd.op  = DP_ZERO;
                ovalid_nxt = 1'b1;
              end else if (val_ok) begin
                locked_nxt = 1'b0;
              end
            end
            ACT_WALK_MODE: begin
              if (val_ok && in_enable) begin
                walk_nxt   = in_value[WALK_W-1:0];
                locked_nxt = 1'b0;
              end else if (val_ok && (walk_r == in_value[WALK_W-1:0])) begin
                walk_nxt   = '0;
                locked_nxt = 1'b1;
                active_nxt = 1'b0;
                dp_cmd.op  = DP_ZERO;
                ovalid_nxt = 1'b1;
              end
            end
            ACT_PROFILE: begin
              if (sport_r != in_enable) begin
                sport_nxt = in_enable;
                if (!locked_r && active_r) begin
                  dp_cmd.op = DP_START;
                  state_nxt = S_SQUARE;
                end
              end
            end
            ACT_SPEED: begin
              high_nxt = (in_value == VAL_ONE);
              if (!sport_r && !locked_r && active_r) begin
                dp_cmd.op = DP_START;
                state_nxt = S_SQUARE;
              end
            end
            ACT_CONTINUOUS: begin
              cont_nxt = in_enable;
              if (!in_enable) ticks_nxt = '0;
            end
            ACT_RESET: begin
              locked_nxt = 1'b1;
              active_nxt = 1'b0;
              cont_nxt   = 1'b0;
              sport_nxt  = 1'b0;
              high_nxt   = 1'b0;
              walk_nxt   = '0;
              ticks_nxt  = '0;
              dp_cmd.op  = DP_CLEAR;
              ovalid_nxt = 1'b1;
            end
            ACT_TICK: begin
              ticks_nxt = ticks_inc;
              if (!locked_r && !cont_r && active_r && (ticks_inc >= timeout_r)) begin
                active_nxt = 1'b0;
                dp_cmd.op  = DP_ZERO;
                ovalid_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SQUARE: begin
        dp_cmd.op = DP_SQUARE;
        state_nxt = S_COMPARE;
      end
      S_COMPARE: begin
        dp_cmd.op = DP_COMPARE;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        cnt_nxt   = '0;
        state_nxt = dp_sts.over ? S_SQRT : S_COMMIT;
      end
      S_SQRT: begin
        dp_cmd.op = DP_SQRT;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (last_iter) state_nxt = S_MUL;
      end
      S_MUL: begin
        dp_cmd.op = DP_MUL;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dp_cmd.op = DP_DIV;
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (last_iter) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          dp_cmd.op  = DP_COMMIT;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // limit follows the flags as they stand after this transaction
    priority if (sport_nxt) dp_cmd.lim_sel = LIM_SPORT;
    else if (high_nxt)      dp_cmd.lim_sel = LIM_AI_HIGH;
    else                    dp_cmd.lim_sel = LIM_AI_LOW;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      locked_r <= 1'b1;
      active_r <= 1'b0;
      cont_r   <= 1'b0;
      sport_r  <= 1'b0;
      high_r   <= 1'b0;
      walk_r   <= '0;
      ticks_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      locked_r <= locked_nxt;
      active_r <= active_nxt;
      cont_r   <= cont_nxt;
      sport_r  <= sport_nxt;
      high_r   <= high_nxt;
      walk_r   <= walk_nxt;
      ticks_r  <= ticks_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TMO_RST;
    end else if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_TIMEOUT)) begin
      timeout_r <= cfg_wdata[TMO_W-1:0];
    end
  end

endmodule
